[rtl/core/lsrp_pkg.sv]
// ----------------------------------------------------------------------------
// lsrp_pkg
// Shared types, widths and constants of the line-sphere reach point unit.
// ----------------------------------------------------------------------------
package lsrp_pkg;

  localparam int FRAC_BITS = 16;
  // 0.6 m in the raw fixed-point format, rounded to nearest
  localparam logic [30:0] RADIUS_RESET = 31'((6 * (2 ** FRAC_BITS) + 5) / 10);

  localparam int AW     = 66;   // a = d.d
  localparam int BW     = 67;   // b = d.w, signed
  localparam int DISCW  = 134;  // discriminant, signed
  localparam int ROOTW  = DISCW / 2;
  localparam int SQREMW = ROOTW + 3;
  localparam int NW     = 69;   // -b +/- root, signed
  localparam int NMW    = NW - 1;
  localparam int NLOW   = 34;
  localparam int TW     = 100;  // |d_k| * |N|
  localparam int REMW   = 102;
  localparam int QUOT_BITS = 36;

  localparam int COEF_STAGES = 7;
  localparam int PREP_STAGES = 4;
  localparam int LATENCY = COEF_STAGES + ROOTW + PREP_STAGES + QUOT_BITS + 1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EQX   = 2'd1,
    ST_NOHIT = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] through_x;
    logic signed [31:0] through_y;
    logic signed [31:0] through_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] reach_x;
    logic signed [31:0] reach_y;
    logic signed [31:0] reach_z;
    logic [1:0]         status;
  } rsp_t;

  // sideband that travels alongside the discriminant and the root
  typedef struct packed {
    logic [AW-1:0]     a;
    logic [BW-1:0]     b;
    logic [2:0][32:0]  d;
    logic [2:0][31:0]  st;
    status_t           status;
  } side_t;

  // per-lane sideband through a divider
  typedef struct packed {
    logic [31:0] st;
    logic        neg;
    status_t     status;
  } lane_tag_t;

endpackage

[rtl/core/lsrp_coef.sv]
// ----------------------------------------------------------------------------
// lsrp_coef
// Quadratic coefficients and discriminant, seven register stages.
// ----------------------------------------------------------------------------
module lsrp_coef (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  lsrp_pkg::req_t                 req,
  input  logic [30:0]                    radius,
  output logic                           out_valid,
  output logic [lsrp_pkg::DISCW-1:0]     disc,
  output lsrp_pkg::side_t                side
);
  import lsrp_pkg::*;

  logic [COEF_STAGES-1:0] vld;
  side_t sd1, sd2, sd3, sd4, sd5, sd6, sd7;

  logic signed [32:0] w1 [3];
  logic [30:0]        r1;
  logic signed [65:0] dd2 [3];
  logic signed [65:0] dw2 [3];
  logic signed [65:0] ww2 [3];
  logic [61:0]        rr2;
  logic signed [BW-1:0] c3;
  logic [AW-1:0]      bm4, cm4;
  logic               cneg4, cneg5, cneg6;
  logic [65:0]        pbhh5, pbhl5, pbll5, pahh5, pahl5, palh5, pall5;
  logic [131:0]       bsq6, ac6;
  logic [DISCW-1:0]   disc7, disc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[COEF_STAGES-2:0], in_valid};
    end
  end

  // stage 1: direction and offset
  always_ff @(posedge clk) begin
    sd1.d[0] <= 33'(req.through_x) - 33'(req.start_x);
    sd1.d[1] <= 33'(req.through_y) - 33'(req.start_y);
    sd1.d[2] <= 33'(req.through_z) - 33'(req.start_z);
    w1[0]    <= 33'(req.start_x) - 33'(req.center_x);
    w1[1]    <= 33'(req.start_y) - 33'(req.center_y);
    w1[2]    <= 33'(req.start_z) - 33'(req.center_z);
    sd1.st[0] <= req.start_x;
    sd1.st[1] <= req.start_y;
    sd1.st[2] <= req.start_z;
    sd1.a     <= '0;
    sd1.b     <= '0;
    sd1.status <= ST_OK;
    r1 <= radius;
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dd2[k] <= $signed(sd1.d[k]) * $signed(sd1.d[k]);
      dw2[k] <= $signed(sd1.d[k]) * w1[k];
      ww2[k] <= w1[k] * w1[k];
    end
    rr2 <= r1 * r1;
    sd2 <= sd1;
  end

  // stage 3: sums
  always_ff @(posedge clk) begin
    sd3.d      <= sd2.d;
    sd3.st     <= sd2.st;
    sd3.status <= sd2.status;
    sd3.a <= AW'(dd2[0]) + AW'(dd2[1]) + AW'(dd2[2]);
    sd3.b <= BW'(dw2[0]) + BW'(dw2[1]) + BW'(dw2[2]);
    c3    <= BW'(ww2[0]) + BW'(ww2[1]) + BW'(ww2[2]) - BW'(rr2);
  end

  // stage 4: magnitudes
  always_ff @(posedge clk) begin
    sd4   <= sd3;
    bm4   <= sd3.b[BW-1] ? AW'(-sd3.b) : AW'(sd3.b);
    cm4   <= c3[BW-1] ? AW'(-c3) : AW'(c3);
    cneg4 <= c3[BW-1];
  end

  // stage 5: partial products on 33-bit halves
  always_ff @(posedge clk) begin
    sd5   <= sd4;
    cneg5 <= cneg4;
    pbhh5 <= bm4[65:33] * bm4[65:33];
    pbhl5 <= bm4[65:33] * bm4[32:0];
    pbll5 <= bm4[32:0] * bm4[32:0];
    pahh5 <= sd4.a[65:33] * cm4[65:33];
    pahl5 <= sd4.a[65:33] * cm4[32:0];
    palh5 <= sd4.a[32:0] * cm4[65:33];
    pall5 <= sd4.a[32:0] * cm4[32:0];
  end

  // stage 6: assemble b*b and a*|c|
  always_ff @(posedge clk) begin
    sd6   <= sd5;
    cneg6 <= cneg5;
    bsq6  <= (132'(pbhh5) << 66) + (132'(pbhl5) << 34) + 132'(pbll5);
    ac6   <= (132'(pahh5) << 66) + ((132'(pahl5) + 132'(palh5)) << 33) + 132'(pall5);
  end

  // stage 7: discriminant and status
  always_comb begin
    if (cneg6) begin
      disc_next = {2'b00, bsq6} + {2'b00, ac6};
    end else begin
      disc_next = {2'b00, bsq6} - {2'b00, ac6};
    end
  end

  always_ff @(posedge clk) begin
    sd7.a  <= sd6.a;
    sd7.b  <= sd6.b;
    sd7.d  <= sd6.d;
    sd7.st <= sd6.st;
    disc7 <= disc_next;
    if (sd6.d[0] == '0) begin
      sd7.status <= ST_EQX;
    end else if (disc_next[DISCW-1]) begin
      sd7.status <= ST_NOHIT;
    end else begin
      sd7.status <= ST_OK;
    end
  end

  assign out_valid = vld[COEF_STAGES-1];
  assign disc      = disc7;
  assign side      = sd7;

endmodule

[rtl/core/lsrp_sqrt.sv]
// ----------------------------------------------------------------------------
// lsrp_sqrt
// Integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module lsrp_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [lsrp_pkg::DISCW-1:0]     rad,
  input  lsrp_pkg::side_t                in_side,
  output logic                           out_valid,
  output logic [lsrp_pkg::ROOTW-1:0]     root,
  output lsrp_pkg::side_t                out_side
);
  import lsrp_pkg::*;

  logic [ROOTW:0]    vld;
  logic [DISCW-1:0]  rad_q  [ROOTW+1];
  logic [SQREMW-1:0] rem_q  [ROOTW+1];
  logic [ROOTW-1:0]  root_q [ROOTW+1];
  side_t             side_q [ROOTW+1];

  assign vld[0]    = in_valid;
  assign rad_q[0]  = rad;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = in_side;

  for (genvar j = 0; j < ROOTW; j++) begin : g_step
    logic [SQREMW-1:0] rem_sh, trial;
    logic              ge;

    assign rem_sh = {rem_q[j][SQREMW-3:0], rad_q[j][DISCW-1 -: 2]};
    assign trial  = SQREMW'({root_q[j], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      rad_q[j+1]  <= rad_q[j] << 2;
      rem_q[j+1]  <= ge ? rem_sh - trial : rem_sh;
      root_q[j+1] <= {root_q[j][ROOTW-2:0], ge};
      side_q[j+1] <= side_q[j];
    end
  end

  assign out_valid = vld[ROOTW];
  assign root      = root_q[ROOTW];
  assign out_side  = side_q[ROOTW];

endmodule

[rtl/core/lsrp_div.sv]
// ----------------------------------------------------------------------------
// lsrp_div
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module lsrp_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [lsrp_pkg::TW-1:0]        num,
  input  logic [lsrp_pkg::AW-1:0]        den,
  input  lsrp_pkg::lane_tag_t            in_tag,
  output logic                           out_valid,
  output logic [lsrp_pkg::QUOT_BITS-1:0] quot,
  output logic                           rem_nz,
  output lsrp_pkg::lane_tag_t            out_tag
);
  import lsrp_pkg::*;

  logic [QUOT_BITS:0]   vld;
  logic [REMW-1:0]      rem_q  [QUOT_BITS+1];
  logic [AW-1:0]        den_q  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quot_q [QUOT_BITS+1];
  lane_tag_t            tag_q  [QUOT_BITS+1];

  assign vld[0]    = in_valid;
  assign rem_q[0]  = REMW'(num);
  assign den_q[0]  = den;
  assign quot_q[0] = '0;
  assign tag_q[0]  = in_tag;

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
    logic [REMW-1:0] dsh;
    logic            ge;

    assign dsh = REMW'(den_q[i]) << (QUOT_BITS - 1 - i);
    assign ge  = rem_q[i] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      rem_q[i+1]  <= ge ? rem_q[i] - dsh : rem_q[i];
      quot_q[i+1] <= {quot_q[i][QUOT_BITS-2:0], ge};
      den_q[i+1]  <= den_q[i];
      tag_q[i+1]  <= tag_q[i];
    end
  end

  assign out_valid = vld[QUOT_BITS];
  assign quot      = quot_q[QUOT_BITS];
  assign rem_nz    = rem_q[QUOT_BITS] != '0;
  assign out_tag   = tag_q[QUOT_BITS];

endmodule

[rtl/core/line_sphere_reach_point_unit.sv]
// ----------------------------------------------------------------------------
// line_sphere_reach_point_unit
// Far-x intersection of a line through two points with a sphere.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request on req (start point, second point, sphere
//   centre, signed Q15.16). A request is taken at every clock edge where
//   start is high and busy is low; busy stays low, so a request may be
//   offered in every cycle.
//   After a request is taken, done pulses for one cycle with the answer
//   on rsp: the intersection point with the larger x, saturated to 32
//   bits, and a status (ok, equal x, no intersection).
//   On an error status the point reads as zero.
//   Throughput is one request per cycle. The latency is set by the 7-stage
//   coefficient pipe, the 67-stage square root (one root bit per stage),
//   4 stages forming the numerators and the 36-stage dividers (one
//   quotient bit per stage), plus the output register.
//   The radius is written through radius_we/radius_wdata; write it only
//   while no request is in flight.
//   rst (synchronous, active high) empties the pipe and loads a radius of
//   0.6 m. The receiver must take done when it comes: there is no hold-off.
// ----------------------------------------------------------------------------
module line_sphere_reach_point_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lsrp_pkg::req_t  req,
  input  logic            radius_we,
  input  logic [30:0]     radius_wdata,
  output logic            done,
  output lsrp_pkg::rsp_t  rsp
);
  import lsrp_pkg::*;

  logic [30:0] radius;

  // hold the sphere radius
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (radius_we) begin
      radius <= radius_wdata;
    end
  end

  // the pipe never stalls
  assign busy = 1'b0;

  // coefficients and discriminant
  logic             cf_valid;
  logic [DISCW-1:0] cf_disc;
  side_t            cf_side;

  lsrp_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .req       (req),
    .radius    (radius),
    .out_valid (cf_valid),
    .disc      (cf_disc),
    .side      (cf_side)
  );

  // square root of the discriminant
  logic             sq_valid;
  logic [ROOTW-1:0] sq_root;
  side_t            sq_side;

  lsrp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cf_valid),
    .rad       (cf_disc),
    .in_side   (cf_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // numerators d_k * (-b +/- root), the root taking the sign of d_x
  logic [PREP_STAGES-1:0] pv;
  side_t                  sdp1, sdp2, sdp3, sdp4;
  logic signed [NW-1:0]   n1;
  logic [NMW-1:0]         nm2;
  logic                   nneg2;
  logic [31:0]            dm2 [3];
  logic                   dneg2 [3];
  logic [65:0]            pl3 [3];
  logic [65:0]            ph3 [3];
  logic                   neg3 [3];
  logic [TW-1:0]          t4 [3];
  logic                   neg4 [3];
  logic                   dx_pos;

  assign dx_pos = !sq_side.d[0][32] && (sq_side.d[0] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[PREP_STAGES-2:0], sq_valid};
    end
  end

  always_ff @(posedge clk) begin
    // P1: signed numerator factor
    sdp1 <= sq_side;
    n1   <= (dx_pos ? NW'(sq_root) : -NW'(sq_root)) - NW'($signed(sq_side.b));
    // P2: magnitudes
    sdp2  <= sdp1;
    nm2   <= n1[NW-1] ? NMW'(-n1) : NMW'(n1);
    nneg2 <= n1[NW-1];
    for (int k = 0; k < 3; k++) begin
      dm2[k]   <= sdp1.d[k][32] ? 32'(-sdp1.d[k]) : 32'(sdp1.d[k]);
      dneg2[k] <= sdp1.d[k][32];
    end
    // P3: partial products on the low and high parts of |N|
    sdp3 <= sdp2;
    for (int k = 0; k < 3; k++) begin
      pl3[k]  <= dm2[k] * nm2[NLOW-1:0];
      ph3[k]  <= dm2[k] * nm2[NMW-1:NLOW];
      neg3[k] <= dneg2[k] ^ nneg2;
    end
    // P4: assemble numerators
    sdp4 <= sdp3;
    for (int k = 0; k < 3; k++) begin
      t4[k]   <= (TW'(ph3[k]) << NLOW) + TW'(pl3[k]);
      neg4[k] <= neg3[k];
    end
  end

  // one divider lane per coordinate
  logic                 dv_valid [3];
  logic [QUOT_BITS-1:0] dv_quot  [3];
  logic                 dv_rnz   [3];
  lane_tag_t            dv_tag   [3];
  lane_tag_t            dv_in    [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign dv_in[k] = '{st: sdp4.st[k], neg: neg4[k], status: sdp4.status};

    lsrp_div u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (pv[PREP_STAGES-1]),
      .num       (t4[k]),
      .den       (sdp4.a),
      .in_tag    (dv_in[k]),
      .out_valid (dv_valid[k]),
      .quot      (dv_quot[k]),
      .rem_nz    (dv_rnz[k]),
      .out_tag   (dv_tag[k])
    );
  end

  // floor the quotient, add the start point and saturate
  logic [QUOT_BITS:0] qf   [3];
  logic [QUOT_BITS+2:0] sum [3];
  logic [31:0]        coord [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qf[k]  = (QUOT_BITS+1)'(dv_quot[k]) + (QUOT_BITS+1)'(dv_tag[k].neg && dv_rnz[k]);
      sum[k] = (QUOT_BITS+3)'($signed(dv_tag[k].st))
             + (dv_tag[k].neg ? -(QUOT_BITS+3)'(qf[k]) : (QUOT_BITS+3)'(qf[k]));
      if (sum[k][QUOT_BITS+2:31] == '0 || sum[k][QUOT_BITS+2:31] == '1) begin
        coord[k] = sum[k][31:0];
      end else if (sum[k][QUOT_BITS+2]) begin
        coord[k] = 32'h8000_0000;
      end else begin
        coord[k] = 32'h7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    rsp.status <= dv_tag[0].status;
    if (dv_tag[0].status == ST_OK) begin
      rsp.reach_x <= coord[0];
      rsp.reach_y <= coord[1];
      rsp.reach_z <= coord[2];
    end else begin
      rsp.reach_x <= '0;
      rsp.reach_y <= '0;
      rsp.reach_z <= '0;
    end
  end

  // every request taken comes back after the fixed latency
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request not answered after pipeline latency");

  // no answer without a request at the matching cycle
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("answer without a matching request");

  // error answers carry a zero point
  assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |->
      (rsp.reach_x == '0 && rsp.reach_y == '0 && rsp.reach_z == '0))
    else $error("error answer with a nonzero point");

  // equal-x status only for a request whose two points share x
  assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_EQX) |-> $past(req.start_x == req.through_x, LATENCY))
    else $error("equal-x status on a request with distinct x");

endmodule
